// ===== rtl/core/cba_pkg.sv =====
// Package for the contiguous block allocator.
// Holds shared widths, reset values and command and status codes.
// No dependencies.
package cba_pkg;

   // Default map size in blocks
   localparam int NUM_BLOCKS_DEF = 1024;

   // Free map row width and its index width
   localparam int WORD_W = 32;
   localparam int LW     = $clog2(WORD_W);

   // Request byte count and block size register
   localparam int BYTES_W       = 32;
   localparam int BLOCK_BYTES_W = 17;
   localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RST = 17'd4096;

   // Command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Status codes
   localparam logic STAT_OK   = 1'b0;
   localparam logic STAT_FAIL = 1'b1;

endpackage

// ===== rtl/core/cba_req_if.sv =====
// Command channel of the contiguous block allocator.
// Carries valid, ready and one command beat; depends on cba_pkg.
interface cba_req_if
   import cba_pkg::*;
   #(parameter int NUM_BLOCKS = NUM_BLOCKS_DEF)
   ();

   localparam int BLK_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   logic               valid;
   logic               ready;
   logic               command;
   logic [BYTES_W-1:0] request_bytes;
   logic [BLK_W-1:0]   first_block;
   logic [CNT_W-1:0]   release_count;

   modport source (
      output valid, command, request_bytes, first_block, release_count,
      input  ready
   );

   modport sink (
      input  valid, command, request_bytes, first_block, release_count,
      output ready
   );

endinterface

// ===== rtl/core/cba_rsp_if.sv =====
// Result channel of the contiguous block allocator.
// Carries valid, ready and one result beat; depends on cba_pkg.
interface cba_rsp_if
   import cba_pkg::*;
   #(parameter int NUM_BLOCKS = NUM_BLOCKS_DEF)
   ();

   localparam int BLK_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   logic             valid;
   logic             ready;
   logic             status;
   logic [BLK_W-1:0] run_start;
   logic [CNT_W-1:0] free_total;

   modport source (
      output valid, status, run_start, free_total,
      input  ready
   );

   modport sink (
      input  valid, status, run_start, free_total,
      output ready
   );

endinterface

// ===== rtl/core/contiguous_block_allocator_top.sv =====
// Allocate: accept, bit-serial divide, range check, scan steps, a row read, one row write per
// row marked, then the result hand-off. One scan step per free or used stretch within a 32-bit
// map row. Free: accept, a row read, one row write per row touched, then the result hand-off.
// One command at a time; the result register lets the next command enter while a result still
// waits. Reset: synchronous, active high, then a clearing pass over every map row marks all
// blocks free.
module contiguous_block_allocator_top
   import cba_pkg::*;
   #(parameter int NUM_BLOCKS = NUM_BLOCKS_DEF)
   (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [BLOCK_BYTES_W-1:0] csr_wr_data,
   cba_req_if.sink                  req_chan,
   cba_rsp_if.source                rsp_chan
   );

   localparam int BLK_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int ROWS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PW    = $clog2(ROWS * WORD_W + 1);
   localparam int DCW   = $clog2(BYTES_W);

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_DIV, ST_CHECK, ST_SCAN, ST_MARK_RD, ST_MARK_WR, ST_DONE
   } state_type;

   // Row holding a block position
   function automatic logic [RW-1:0] row_of(input logic [PW-1:0] p);
      return RW'(p >> LW);
   endfunction

   // Length of the run of ones starting at bit 0
   function automatic logic [LW:0] ones_run(input logic [WORD_W-1:0] v);
      logic [LW:0] n;
      n = (LW+1)'(WORD_W);
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!v[i]) n = (LW+1)'(i);
      end
      return n;
   endfunction

   // Bits of one row whose block index lies in [lo, hi)
   function automatic logic [WORD_W-1:0] row_mask(input logic [RW-1:0] r,
                                                  input logic [PW-1:0] lo,
                                                  input logic [PW-1:0] hi);
      logic [WORD_W-1:0] m;
      logic [PW-1:0]     idx;
      m = '0;
      for (int i = 0; i < WORD_W; i++) begin
         idx  = PW'({r, LW'(i)});
         m[i] = (idx >= lo) && (idx < hi);
      end
      return m;
   endfunction

   function automatic logic [LW:0] pop_count(input logic [WORD_W-1:0] v);
      logic [LW:0] n;
      n = '0;
      for (int i = 0; i < WORD_W; i++) begin
         n = n + (LW+1)'(v[i]);
      end
      return n;
   endfunction

   // Free map rows
   logic [WORD_W-1:0] map_mem [ROWS];
   logic [WORD_W-1:0] rd_data_ff;
   logic [RW-1:0]     rd_addr;
   logic [RW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              wr_en;

   state_type                state_ff, state_in;
   logic [BLOCK_BYTES_W-1:0] block_bytes_ff, block_bytes_in;
   logic                     cmd_ff, cmd_in;
   logic [BYTES_W-1:0]       quot_ff, quot_in;
   logic [BLOCK_BYTES_W-1:0] rem_ff, rem_in;
   logic [DCW-1:0]           div_cnt_ff, div_cnt_in;
   logic [CNT_W-1:0]         needed_ff, needed_in;
   logic [PW-1:0]            pos_ff, pos_in;
   logic [CNT_W-1:0]         run_ff, run_in;
   logic [PW-1:0]            begin_ff, begin_in;
   logic [PW-1:0]            range_lo_ff, range_lo_in;
   logic [PW-1:0]            range_hi_ff, range_hi_in;
   logic [RW-1:0]            mark_row_ff, mark_row_in;
   logic [RW-1:0]            last_row_ff, last_row_in;
   logic [CNT_W-1:0]         tally_ff, tally_in;
   logic                     res_status_ff, res_status_in;
   logic [BLK_W-1:0]         res_start_ff, res_start_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_status_ff, rsp_status_in;
   logic [BLK_W-1:0]         rsp_start_ff, rsp_start_in;
   logic [CNT_W-1:0]         rsp_total_ff, rsp_total_in;

   // Shared datapath terms
   logic [BLOCK_BYTES_W-1:0] divisor;
   logic [BLOCK_BYTES_W:0]   rem_shift;
   logic [BLOCK_BYTES_W:0]   rem_diff;
   logic                     rem_ge;
   logic [BYTES_W:0]         needed_wide;
   logic [LW-1:0]            bit_off;
   logic                     bit_free;
   logic [WORD_W-1:0]        probe;
   logic [LW:0]              step;
   logic [CNT_W:0]           run_sum;
   logic [PW-1:0]            begin_sel;
   logic [PW-1:0]            alloc_hi;
   logic [CNT_W:0]           free_end;
   logic [CNT_W:0]           free_clip;
   logic [WORD_W-1:0]        mask;
   logic                     req_take;

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign req_take            = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.run_start  = rsp_start_ff;
   assign rsp_chan.free_total = rsp_total_ff;

   // Restoring divider step, one quotient bit a cycle
   assign divisor   = (block_bytes_ff == '0) ? BLOCK_BYTES_W'(1) : block_bytes_ff;
   assign rem_shift = {rem_ff, quot_ff[BYTES_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor};
   assign rem_ge    = (rem_shift >= {1'b0, divisor});
   assign needed_wide = {1'b0, quot_ff} + (BYTES_W+1)'(rem_ff != '0);

   // Scan step: length of the stretch from the cursor to the next change of bit value or the row end
   assign bit_off   = pos_ff[LW-1:0];
   assign bit_free  = rd_data_ff[bit_off];
   assign probe     = bit_free ? (rd_data_ff >> bit_off) : (~rd_data_ff >> bit_off);
   assign step      = ones_run(probe);
   assign run_sum   = (CNT_W+1)'(run_ff) + (CNT_W+1)'(step);
   assign begin_sel = (run_ff == '0) ? pos_ff : begin_ff;
   assign alloc_hi  = begin_sel + PW'(needed_ff);

   // Free range, clipped at the map end
   assign free_end  = (CNT_W+1)'(req_chan.first_block) + (CNT_W+1)'(req_chan.release_count);
   assign free_clip = (free_end > (CNT_W+1)'(NUM_BLOCKS)) ? (CNT_W+1)'(NUM_BLOCKS) : free_end;

   assign mask = (state_ff == ST_INIT)
                 ? row_mask(mark_row_ff, '0, PW'(NUM_BLOCKS))
                 : row_mask(mark_row_ff, range_lo_ff, range_hi_ff);

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      block_bytes_in = csr_wr_en ? csr_wr_data : block_bytes_ff;
      cmd_in         = cmd_ff;
      quot_in        = quot_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      needed_in      = needed_ff;
      pos_in         = pos_ff;
      run_in         = run_ff;
      begin_in       = begin_ff;
      range_lo_in    = range_lo_ff;
      range_hi_in    = range_hi_ff;
      mark_row_in    = mark_row_ff;
      last_row_in    = last_row_ff;
      tally_in       = tally_ff;
      res_status_in  = res_status_ff;
      res_start_in   = res_start_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_total_in   = rsp_total_ff;
      rd_addr        = row_of(pos_ff);
      wr_en          = 1'b0;
      wr_addr        = mark_row_ff;
      wr_data        = rd_data_ff;

      unique case (state_ff)
         ST_INIT: begin
            // clear the map to all free, one row a cycle
            wr_en   = 1'b1;
            wr_data = mask;
            if (mark_row_ff == RW'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               mark_row_in = mark_row_ff + RW'(1);
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               cmd_in        = req_chan.command;
               res_status_in = STAT_OK;
               res_start_in  = '0;
               if (req_chan.command == CMD_ALLOC) begin
                  quot_in    = req_chan.request_bytes;
                  rem_in     = '0;
                  div_cnt_in = '0;
                  pos_in     = '0;
                  run_in     = '0;
                  state_in   = ST_DIV;
               end else if ((CNT_W+1)'(req_chan.first_block) >= (CNT_W+1)'(NUM_BLOCKS) ||
                            req_chan.release_count == '0) begin
                  state_in = ST_DONE;
               end else begin
                  range_lo_in = PW'(req_chan.first_block);
                  range_hi_in = PW'(free_clip);
                  mark_row_in = row_of(PW'(req_chan.first_block));
                  last_row_in = row_of(PW'(free_clip) - PW'(1));
                  state_in    = ST_MARK_RD;
               end
            end
         end
         ST_DIV: begin
            quot_in = {quot_ff[BYTES_W-2:0], rem_ge};
            rem_in  = rem_ge ? rem_diff[BLOCK_BYTES_W-1:0] : rem_shift[BLOCK_BYTES_W-1:0];
            div_cnt_in = div_cnt_ff + DCW'(1);
            if (div_cnt_ff == DCW'(BYTES_W - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // round up and reject sizes beyond the map
            if (needed_wide > (BYTES_W+1)'(NUM_BLOCKS)) begin
               res_status_in = STAT_FAIL;
               state_in      = ST_DONE;
            end else begin
               needed_in = CNT_W'(needed_wide);
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pos_ff >= PW'(NUM_BLOCKS)) begin
               res_status_in = STAT_FAIL;
               state_in      = ST_DONE;
            end else if (bit_free) begin
               if (run_sum >= (CNT_W+1)'(needed_ff)) begin
                  // grant at the start of this run
                  res_start_in = BLK_W'(begin_sel);
                  tally_in     = tally_ff - needed_ff;
                  range_lo_in  = begin_sel;
                  range_hi_in  = alloc_hi;
                  mark_row_in  = row_of(begin_sel);
                  last_row_in  = row_of(alloc_hi - PW'(1));
                  state_in     = (needed_ff == '0) ? ST_DONE : ST_MARK_RD;
               end else begin
                  begin_in = begin_sel;
                  run_in   = CNT_W'(run_sum);
                  pos_in   = pos_ff + PW'(step);
               end
            end else begin
               run_in = '0;
               pos_in = pos_ff + PW'(step);
            end
            rd_addr = row_of(pos_in);
         end
         ST_MARK_RD: begin
            rd_addr  = mark_row_ff;
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            // update one row, fetch the next one
            wr_en = 1'b1;
            if (cmd_ff == CMD_FREE) begin
               wr_data  = rd_data_ff | mask;
               tally_in = tally_ff + CNT_W'(pop_count(mask & ~rd_data_ff));
            end else begin
               wr_data = rd_data_ff & ~mask;
            end
            rd_addr = mark_row_ff + RW'(1);
            if (mark_row_ff == last_row_ff) begin
               state_in = ST_DONE;
            end else begin
               mark_row_in = mark_row_ff + RW'(1);
            end
         end
         ST_DONE: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_total_in  = tally_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      needed_ff     <= needed_in;
      pos_ff        <= pos_in;
      run_ff        <= run_in;
      begin_ff      <= begin_in;
      range_lo_ff   <= range_lo_in;
      range_hi_ff   <= range_hi_in;
      last_row_ff   <= last_row_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_total_ff  <= rsp_total_in;
      if (reset) begin
         state_ff       <= ST_INIT;
         block_bytes_ff <= BLOCK_BYTES_RST;
         mark_row_ff    <= '0;
         tally_ff       <= CNT_W'(NUM_BLOCKS);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         block_bytes_ff <= block_bytes_in;
         mark_row_ff    <= mark_row_in;
         tally_ff       <= tally_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Map row storage: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

endmodule
